/* rtl/core/assert_macros.svh */
// assertion macros used by the core top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

/* rtl/core/cfd_pkg.sv */
// shared types and constants for the float widening core
package cfd_pkg;
  localparam logic [63:0] EXP_ONES  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [12:0] DBL_BIAS  = 13'd1023;
  localparam logic [12:0] DBL_EMAX  = 13'h7FF;
  localparam logic CFG_EXP = 1'b0;
  localparam logic CFG_FRAC = 1'b1;

  localparam logic [1:0] CLS_NORM = 2'd0;
  localparam logic [1:0] CLS_SUB  = 2'd1;
  localparam logic [1:0] CLS_INF  = 2'd2;
  localparam logic [1:0] CLS_NAN  = 2'd3;

  // fields after unpacking
  typedef struct packed {
    logic        sign;
    logic [1:0]  cls;
    logic        zero;
    logic [51:0] frac_al;   // fraction left aligned to 52 bits
    logic [12:0] ev;        // signed unbiased exponent
    logic [5:0]  t;
  } unpk_t;

  // after leading-zero count
  typedef struct packed {
    logic        sign;
    logic [1:0]  cls;
    logic        zero;
    logic [51:0] frac_al;
    logic [12:0] ev;
    logic [5:0]  t;
    logic [5:0]  lz;        // leading zeros of aligned fraction
  } norm_t;
endpackage

/* rtl/core/cfd_unpack.sv */
// stage one: clamp widths and split the raw word into fields
module cfd_unpack (
  input  logic [3:0]   exp_w,
  input  logic [5:0]   frac_w,
  input  logic [63:0]  raw,
  output cfd_pkg::unpk_t u
);
  logic [3:0]  w;
  logic [5:0]  t;
  logic [63:0] m, e, s_sh;
  logic [10:0] emax;
  logic [12:0] bias;
  always_comb begin
    w = (exp_w < 4'd2) ? 4'd2 : ((exp_w > 4'd11) ? 4'd11 : exp_w);
    t = (frac_w < 6'd1) ? 6'd1 : ((frac_w > 6'd52) ? 6'd52 : frac_w);
    m = raw & ((64'd1 << t) - 64'd1);
    e = (raw >> t) & ((64'd1 << w) - 64'd1);
    s_sh = raw >> (7'(t) + 7'(w));
    emax = 11'((12'd1 << w) - 12'd1);
    bias = 13'((13'd1 << (w - 4'd1)) - 13'd1);
    u.sign = s_sh[0];
    u.t = t;
    u.frac_al = 52'(m << (6'd52 - t));
    u.zero = (m == 64'd0);
    if (e[10:0] == emax) u.cls = u.zero ? cfd_pkg::CLS_INF : cfd_pkg::CLS_NAN;
    else if (e == 64'd0) u.cls = cfd_pkg::CLS_SUB;
    else u.cls = cfd_pkg::CLS_NORM;
    u.ev = (e == 64'd0) ? (13'd1 - bias) : (13'(e[10:0]) - bias);
  end
endmodule

/* rtl/core/cfd_lzc.sv */
// stage two: leading-zero count of the aligned fraction
module cfd_lzc (
  input  cfd_pkg::unpk_t u,
  output cfd_pkg::norm_t n
);
  logic [5:0] lz;
  logic       found;
  always_comb begin
    lz = 6'd52;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && u.frac_al[i]) begin
        lz = 6'(51 - i);
        found = 1'b1;
      end
    end
    n.sign = u.sign;
    n.cls = u.cls;
    n.zero = u.zero;
    n.frac_al = u.frac_al;
    n.ev = u.ev;
    n.t = u.t;
    n.lz = lz;
  end
endmodule

/* rtl/core/cfd_pack.sv */
// stage three: build value and ulp patterns
module cfd_pack (
  input  cfd_pkg::norm_t n,
  output logic [63:0]    value_bits,
  output logic [63:0]    ulp_bits
);
  logic signed [13:0] be, ue, k;
  logic [5:0]  sub_sh;
  logic [63:0] sgn;
  always_comb begin
    sgn = {n.sign, 63'd0};
    // exponent of leading one: ev - 1 - lz, biased
    be = $signed({n.ev[12], n.ev}) - 14'sd1 - $signed({8'd0, n.lz}) + 14'sd1023;
    ue = $signed({n.ev[12], n.ev}) - $signed({8'd0, n.t});
    k = ue + 14'sd1074;
    // only used when the result stays a binary64 subnormal, where it lies in 0..51
    sub_sh = 6'(n.ev + 13'd1022);
    case (n.cls)
      cfd_pkg::CLS_INF: begin
        value_bits = sgn | cfd_pkg::EXP_ONES;
        ulp_bits = cfd_pkg::EXP_ONES;
      end
      cfd_pkg::CLS_NAN: begin
        value_bits = sgn | cfd_pkg::QNAN_BITS | {12'd0, n.frac_al};
        ulp_bits = cfd_pkg::QNAN_BITS;
      end
      default: begin
        if (n.cls == cfd_pkg::CLS_NORM)
          value_bits = sgn | {1'b0, 11'(n.ev + cfd_pkg::DBL_BIAS), n.frac_al};
        else if (n.zero)
          value_bits = sgn;
        else if (be >= 14'sd1)
          value_bits = sgn | {1'b0, be[10:0], 52'(n.frac_al << (n.lz + 6'd1))};
        else
          // binary64 subnormal: aligned fraction moves up by ev+1022
          value_bits = sgn | {12'd0, 52'(n.frac_al << sub_sh)};
        if (ue + 14'sd1023 >= 14'sd2047) ulp_bits = cfd_pkg::EXP_ONES;
        else if (ue + 14'sd1023 >= 14'sd1) ulp_bits = {1'b0, 11'(ue + 14'sd1023), 52'd0};
        else if (k < 14'sd0) ulp_bits = 64'd0;
        else ulp_bits = 64'd1 << k[5:0];
      end
    endcase
  end
endmodule

/* rtl/core/custom_float_to_double_with_ulp_core.sv */
// Widens one word of a configurable IEEE-style format to binary64 value and ulp patterns.
// Three register stages (unpack, leading-zero count, pack); one item per cycle when the
// output is not stalled. A stall holds every stage in place.
`include "assert_macros.svh"
module custom_float_to_double_with_ulp_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_raw_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value_bits,
  output logic [63:0] out_ulp_bits
);
  logic [3:0] exp_w_r;
  logic [5:0] frac_w_r;
  logic v1_r, v2_r, v3_r, adv;
  cfd_pkg::unpk_t u, u_r;
  cfd_pkg::norm_t n, n_r;
  logic [63:0] val, ulp;

  assign adv = !out_stall || !v3_r;
  assign in_stall = !adv;
  assign out_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_w_r <= 4'd8;
      frac_w_r <= 6'd23;
    end else if (cfg_we) begin
      if (cfg_index == cfd_pkg::CFG_EXP) exp_w_r <= cfg_data[3:0];
      else frac_w_r <= cfg_data;
    end
  end

  cfd_unpack u_unpack (.exp_w(exp_w_r), .frac_w(frac_w_r), .raw(in_raw_word), .u(u));
  cfd_lzc    u_lzc    (.u(u_r), .n(n));
  cfd_pack   u_pack   (.n(n_r), .value_bits(val), .ulp_bits(ulp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r <= u;
      n_r <= n;
      out_value_bits <= val;
      out_ulp_bits <= ulp;
    end
  end

  `ASSERT_CLK(a_stall_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_value_bits))
  `ASSERT_CLK(a_in_stall, clk, rst_n, in_stall |-> out_valid && out_stall)
  `ASSERT_CLK(a_flow, clk, rst_n, v2_r && !in_stall |=> out_valid)
endmodule
